// ===== hw/rtl/y2rgb_pkg.sv =====
package y2rgb_pkg;

	localparam int MAX_DIMENSION = 4096;
	localparam int DIM_W = 13;
	localparam int CNT_W = 12;
	localparam int IDX_W = 24;
	localparam int OFF_W = 10;

	localparam int DIV100_RECIP = 5243;
	localparam int DIV100_SHIFT = 19;

	localparam int COEF_RV = 140;
	localparam int COEF_GU = 34;
	localparam int COEF_GV = 71;
	localparam int COEF_BU = 177;

	localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} dims_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             frame_end;
	} raster_pos_t;

	typedef struct packed {
		logic signed [OFF_W-1:0] r_off;
		logic signed [OFF_W-1:0] g_off;
		logic signed [OFF_W-1:0] b_off;
	} chroma_off_t;

	// n < 2^15, so the reciprocal product is exact after the shift
	function automatic logic [7:0] div100(input logic [14:0] n);
		logic [27:0] prod;
		prod = 28'(n) * 28'(DIV100_RECIP);
		return prod[DIV100_SHIFT +: 8];
	endfunction

	// signed term coef*d/100, truncated toward zero; d given as sign and magnitude
	function automatic logic signed [OFF_W-1:0] chroma_term(
		input logic [7:0] mag,
		input logic       neg,
		input logic [7:0] coef
	);
		logic [14:0] p;
		logic [7:0]  q;
		p = 15'(mag) * 15'(coef);
		q = div100(p);
		return neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
	endfunction

	function automatic logic [7:0] clamp8(input logic signed [OFF_W:0] v);
		if (v < 0) begin
			return 8'd0;
		end else if (v > 11'sd255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return 13'd1;
		end else if (v > 13'(MAX_DIMENSION)) begin
			return 13'(MAX_DIMENSION);
		end
		return v;
	endfunction

endpackage

// ===== hw/rtl/y2rgb_in_if.sv =====
interface y2rgb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_luma;
	logic [7:0] blue_diff;
	logic [7:0] second_luma;
	logic [7:0] red_diff;

	modport source(output valid, output first_luma, output blue_diff,
		output second_luma, output red_diff, input ready);
	modport sink(input valid, input first_luma, input blue_diff,
		input second_luma, input red_diff, output ready);
endinterface

// ===== hw/rtl/y2rgb_out_if.sv =====
interface y2rgb_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] pixel_index;
	logic [7:0]  blue;
	logic [7:0]  green;
	logic [7:0]  red;
	logic        last_of_pair;
	logic        frame_end;

	modport source(output valid, output pixel_index, output blue, output green,
		output red, output last_of_pair, output frame_end, input ready);
	modport sink(input valid, input pixel_index, input blue, input green,
		input red, input last_of_pair, input frame_end, output ready);
endinterface

// ===== hw/rtl/y2rgb_chroma.sv =====
module y2rgb_chroma (
	input  logic [7:0]            blue_diff,
	input  logic [7:0]            red_diff,
	output y2rgb_pkg::chroma_off_t offs
);
	import y2rgb_pkg::*;

	logic       u_neg;
	logic       v_neg;
	logic [7:0] u_mag;
	logic [7:0] v_mag;

	// sign and magnitude of the byte minus 128
	assign u_neg = ~blue_diff[7];
	assign v_neg = ~red_diff[7];
	assign u_mag = u_neg ? 8'(9'd128 - 9'(blue_diff)) : {1'b0, blue_diff[6:0]};
	assign v_mag = v_neg ? 8'(9'd128 - 9'(red_diff)) : {1'b0, red_diff[6:0]};

	assign offs.r_off = chroma_term(v_mag, v_neg, 8'(COEF_RV));
	assign offs.b_off = chroma_term(u_mag, u_neg, 8'(COEF_BU));
	assign offs.g_off = -chroma_term(u_mag, u_neg, 8'(COEF_GU))
		- chroma_term(v_mag, v_neg, 8'(COEF_GV));
endmodule

// ===== hw/rtl/y2rgb_raster.sv =====
module y2rgb_raster (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  y2rgb_pkg::dims_t      dims,
	output y2rgb_pkg::raster_pos_t pos
);
	import y2rgb_pkg::*;

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [DIM_W-1:0] w;
	logic [DIM_W-1:0] h;
	logic             col_over;
	logic [DIM_W-1:0] row_t;
	logic [CNT_W-1:0] col_pre;
	logic [CNT_W-1:0] row_pre;
	logic [CNT_W-1:0] row_flip;
	logic [DIM_W+CNT_W-1:0] prod;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;

	assign w = eff_dim(dims.width);
	assign h = eff_dim(dims.height);

	// fold counters back into range in case the dimensions shrank
	assign col_over = 13'(col_q) >= w;
	assign col_pre  = col_over ? '0 : col_q;
	assign row_t    = col_over ? 13'(row_q) + 13'd1 : 13'(row_q);
	assign row_pre  = (row_t >= h) ? '0 : row_t[CNT_W-1:0];

	assign row_flip = 12'(h - 13'd1 - 13'(row_pre));
	assign prod     = 25'(row_flip) * 25'(w);
	assign pos.index = 24'(prod + 25'(col_pre));
	assign pos.frame_end = (13'(col_pre) == w - 13'd1) && (13'(row_pre) == h - 13'd1);

	assign col_inc = 13'(col_pre) + 13'd1;
	assign row_inc = 13'(row_pre) + 13'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (col_inc >= w) begin
				col_q <= '0;
				row_q <= (row_inc >= h) ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_q <= col_inc[CNT_W-1:0];
				row_q <= row_pre;
			end
		end
	end
endmodule

// ===== hw/rtl/yuyv_to_rgb24_bottom_up.sv =====
// YUYV pair to two BGR pixels with bottom-up raster index.
// Flow: each input beat is registered into the pair stage, then its two pixels
// are registered into the output register in turn, one pixel per cycle while
// the output is ready; a new beat is taken as the second pixel moves out.
// Reset: pipeline empty, raster at top-left, frame 640 x 480.
module yuyv_to_rgb24_bottom_up (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [y2rgb_pkg::DIM_W-1:0] cfg_data,
	y2rgb_in_if.sink                    in_ch,
	y2rgb_out_if.source                 out_ch
);
	import y2rgb_pkg::*;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	logic        valid_s1;
	logic        phase_s1;
	logic [7:0]  y0_s1;
	logic [7:0]  y1_s1;
	chroma_off_t offs_s1;
	chroma_off_t offs_in;

	logic        out_valid_q;
	logic [23:0] index_q;
	logic [7:0]  blue_q;
	logic [7:0]  green_q;
	logic [7:0]  red_q;
	logic        last_q;
	logic        fend_q;

	logic        out_free;
	logic        step;
	logic        in_take;
	logic [7:0]  y_cur;
	logic signed [OFF_W:0] r_sum;
	logic signed [OFF_W:0] g_sum;
	logic signed [OFF_W:0] b_sum;
	dims_t       dims;
	raster_pos_t pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	y2rgb_chroma u_chroma (
		.blue_diff(in_ch.blue_diff),
		.red_diff (in_ch.red_diff),
		.offs     (offs_in)
	);

	assign out_free = !out_valid_q || out_ch.ready;
	assign step     = valid_s1 && out_free;
	// take a new beat when the pair stage is empty or once the second pixel of the held pair moves out
	assign in_ch.ready = !valid_s1 || (step && phase_s1);
	assign in_take     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
			phase_s1 <= 1'b0;
		end else if (step) begin
			valid_s1 <= !phase_s1;
			phase_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			y0_s1   <= in_ch.first_luma;
			y1_s1   <= in_ch.second_luma;
			offs_s1 <= offs_in;
		end
	end

	assign dims.width  = width_q;
	assign dims.height = height_q;

	y2rgb_raster u_raster (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.dims  (dims),
		.pos   (pos)
	);

	assign y_cur = phase_s1 ? y1_s1 : y0_s1;
	assign r_sum = $signed({3'b000, y_cur}) + (OFF_W+1)'(offs_s1.r_off);
	assign g_sum = $signed({3'b000, y_cur}) + (OFF_W+1)'(offs_s1.g_off);
	assign b_sum = $signed({3'b000, y_cur}) + (OFF_W+1)'(offs_s1.b_off);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			index_q <= pos.index;
			fend_q  <= pos.frame_end;
			last_q  <= phase_s1;
			red_q   <= clamp8(r_sum);
			green_q <= clamp8(g_sum);
			blue_q  <= clamp8(b_sum);
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.pixel_index  = index_q;
	assign out_ch.blue         = blue_q;
	assign out_ch.green        = green_q;
	assign out_ch.red          = red_q;
	assign out_ch.last_of_pair = last_q;
	assign out_ch.frame_end    = fend_q;
endmodule
